// ===== rtl/core/tscu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the temperature compensation unit.
package tscu_pkg;

  localparam int RAW_W      = 16;  // raw reading and calibration word width
  localparam int OUT_W      = 24;  // compensated result width
  localparam int X1_W       = 18;  // |X1| <= 131070
  localparam int NUM_W      = 27;  // |mc| * 2^11 <= 2^26
  localparam int DV_W       = 18;  // |X1 + md| <= 163838
  localparam int DIV_STAGES = NUM_W;  // one quotient bit per stage
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AC5 = 2'd0,
    CFG_AC6 = 2'd1,
    CFG_MC  = 2'd2,
    CFG_MD  = 2'd3
  } cfg_reg_t;

  // Divider request: magnitudes plus the sideband that rides along.
  typedef struct packed {
    logic [NUM_W-1:0]        num;
    logic [DV_W-1:0]         dv;
    logic signed [X1_W-1:0]  x1;
    logic                    qneg;
    logic                    dz;
  } div_req_t;

  typedef struct packed {
    logic [NUM_W-1:0]        q;
    logic signed [X1_W-1:0]  x1;
    logic                    qneg;
    logic                    dz;
  } div_rsp_t;

endpackage

// ===== rtl/core/tscu_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one raw temperature reading per transfer.
interface tscu_in_if import tscu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temp;

  modport source (output valid, output raw_temp, input ready);
  modport sink   (input valid, input raw_temp, output ready);
endinterface

// ===== rtl/core/tscu_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: compensated temperature and zero-divisor flag per transfer.
interface tscu_out_if import tscu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] temp_tenths;
  logic                    div_zero;

  modport source (output valid, output temp_tenths, output div_zero, input ready);
  modport sink   (input valid, input temp_tenths, input div_zero, output ready);
endinterface

// ===== rtl/core/temperature_sensor_compensation_unit.sv =====
`timescale 1ns / 1ps
// Top level: raw temperature reading to compensated tenths of a degree.
// Path from input transfer to result valid: 4 front stages,
//   27 divider stages at one quotient bit each, 2 back stages.
// Throughput: one reading per cycle; stalls collapse bubbles stage by stage.
// Reset (rst_n, synchronous, active low) empties the pipeline and clears the
//   four calibration registers to zero.
module temperature_sensor_compensation_unit import tscu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tscu_in_if.sink              in_ch,
  tscu_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [RAW_W-1:0]     cfg_wdata
);

  // calibration words
  logic [RAW_W-1:0] ac5_r, ac6_r, mc_r, md_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac5_r <= '0;
      ac6_r <= '0;
      mc_r  <= '0;
      md_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_AC5: ac5_r <= cfg_wdata;
        CFG_AC6: ac6_r <= cfg_wdata;
        CFG_MC:  mc_r  <= cfg_wdata;
        CFG_MD:  md_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: each stage loads when empty or when its successor loads.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;
  logic div_req_ready, div_rsp_valid;
  div_rsp_t div_rsp;

  assign adv6        = !v6_r || out_ch.ready;
  assign adv5        = !v5_r || adv6;
  assign adv4        = !v4_r || div_req_ready;
  assign adv3        = !v3_r || adv4;
  assign adv2        = !v2_r || adv3;
  assign adv1        = !v1_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= div_rsp_valid;
      if (adv6) v6_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset removal, raw - ac6 (17-bit signed).
  // ---------------------------------------------------------------------
  logic signed [RAW_W:0] d_r;

  always_ff @(posedge clk) begin
    if (adv1) d_r <= $signed({1'b0, in_ch.raw_temp}) - $signed({1'b0, ac6_r});
  end

  // ---------------------------------------------------------------------
  // Stage 2: gain multiply, 17x17 signed; |product| < 2^32.
  // ---------------------------------------------------------------------
  logic signed [2*RAW_W+1:0] prod;
  logic signed [2*RAW_W:0]   p_r;

  assign prod = d_r * $signed({1'b0, ac5_r});

  always_ff @(posedge clk) begin
    if (adv2) p_r <= $signed(prod[2*RAW_W:0]);
  end

  // ---------------------------------------------------------------------
  // Stage 3: X1 = product / 2^15 truncated toward zero.
  // Negative values get a bias of 2^15-1 before the arithmetic shift.
  // ---------------------------------------------------------------------
  logic signed [2*RAW_W:0] p_bias;
  logic signed [2*RAW_W:0] p_sh;
  logic signed [X1_W-1:0]  x1_s3_r;

  assign p_bias = p_r + (p_r[2*RAW_W] ? 33'sd32767 : 33'sd0);
  assign p_sh   = p_bias >>> 15;

  always_ff @(posedge clk) begin
    if (adv3) x1_s3_r <= $signed(p_sh[X1_W-1:0]);
  end

  // ---------------------------------------------------------------------
  // Stage 4: divisor X1 + md, split into magnitudes and a quotient sign.
  // Dividend is |mc| * 2^11.
  // ---------------------------------------------------------------------
  logic signed [DV_W:0] den;
  logic [DV_W:0]        den_abs;
  logic [RAW_W-1:0]     mc_abs;
  div_req_t             req_r;

  assign den     = {x1_s3_r[X1_W-1], x1_s3_r} + {{(DV_W+1-RAW_W){md_r[RAW_W-1]}}, md_r};
  assign den_abs = den[DV_W] ? (~den + 1'b1) : den;
  assign mc_abs  = mc_r[RAW_W-1] ? (~mc_r + 1'b1) : mc_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      req_r.num  <= {mc_abs, 11'b0};
      req_r.dv   <= den_abs[DV_W-1:0];
      req_r.x1   <= x1_s3_r;
      req_r.qneg <= mc_r[RAW_W-1] ^ den[DV_W];
      req_r.dz   <= (den == '0);
    end
  end

  tscu_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v4_r),
    .req_ready (div_req_ready),
    .req       (req_r),
    .rsp_valid (div_rsp_valid),
    .rsp_ready (adv5),
    .rsp       (div_rsp)
  );

  // ---------------------------------------------------------------------
  // Stage 5: signed X2; a zero divisor forces X2 to zero and sets the flag.
  // ---------------------------------------------------------------------
  logic signed [NUM_W:0]  x2_r;
  logic signed [X1_W-1:0] x1_s5_r;
  logic                   dz_s5_r;
  logic [NUM_W:0]         q_ext;

  assign q_ext = {1'b0, div_rsp.q};

  always_ff @(posedge clk) begin
    if (adv5) begin
      x1_s5_r <= div_rsp.x1;
      dz_s5_r <= div_rsp.dz;
      if (div_rsp.dz)        x2_r <= '0;
      else if (div_rsp.qneg) x2_r <= $signed(~q_ext + 1'b1);
      else                   x2_r <= $signed(q_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: (X1 + X2 + 8) >>> 4 into the output register.
  // ---------------------------------------------------------------------
  logic signed [NUM_W+1:0] b5;
  logic signed [NUM_W+1:0] b5_sh;
  logic signed [OUT_W-1:0] temp_r;
  logic                    dz_r;

  assign b5    = {{(NUM_W+2-X1_W){x1_s5_r[X1_W-1]}}, x1_s5_r}
               + {x2_r[NUM_W], x2_r} + 29'sd8;
  assign b5_sh = b5 >>> 4;

  always_ff @(posedge clk) begin
    if (adv6) begin
      temp_r <= $signed(b5_sh[OUT_W-1:0]);
      dz_r   <= dz_s5_r;
    end
  end

  assign out_ch.valid       = v6_r;
  assign out_ch.temp_tenths = temp_r;
  assign out_ch.div_zero    = dz_r;

endmodule

// ===== rtl/core/tscu_divider.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tscu_divider import tscu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  div_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output div_rsp_t rsp
);

  typedef struct packed {
    logic [DV_W-1:0]         rem;
    logic [NUM_W-1:0]        nq;   // dividend bits shift out, quotient bits shift in
    logic [DV_W-1:0]         dv;
    logic signed [X1_W-1:0]  x1;
    logic                    qneg;
    logic                    dz;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t      o;
    logic [DV_W:0]   trial;
    logic            ge;
    trial = {s.rem, s.nq[NUM_W-1]};
    ge    = (trial >= {1'b0, s.dv});
    o     = s;
    o.rem = ge ? DV_W'(trial - {1'b0, s.dv}) : trial[DV_W-1:0];
    o.nq  = {s.nq[NUM_W-2:0], ge};
    return o;
  endfunction

  div_stage_t              st_r   [DIV_STAGES];
  div_stage_t              st_in  [DIV_STAGES];
  logic [DIV_STAGES-1:0]   v_r;
  logic [DIV_STAGES-1:0]   v_in;
  logic [DIV_STAGES:0]     adv;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv[DIV_STAGES] = rsp_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign req_ready = adv[0];
  assign v_in      = {v_r[DIV_STAGES-2:0], req_valid};

  always_comb begin
    st_in[0] = '{rem: '0, nq: req.num, dv: req.dv, x1: req.x1, qneg: req.qneg, dz: req.dz};
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_in[k] = st_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (adv[k]) v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (adv[k]) st_r[k] <= div_step(st_in[k]);
    end
  end

  assign rsp_valid = v_r[DIV_STAGES-1];
  assign rsp.q     = st_r[DIV_STAGES-1].nq;
  assign rsp.x1    = st_r[DIV_STAGES-1].x1;
  assign rsp.qneg  = st_r[DIV_STAGES-1].qneg;
  assign rsp.dz    = st_r[DIV_STAGES-1].dz;

endmodule

// ===== rtl/core/tscu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the compensation unit, bound to the top level.
module tscu_checker import tscu_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_temp_tenths,
  input logic                    out_div_zero
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp_tenths) && $stable(out_div_zero))
    else $error("result changed while stalled");

  // input backpressure only when the output is stalled with a result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // input is ready as soon as reset lifts
  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind temperature_sensor_compensation_unit tscu_checker u_tscu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_temp_tenths (out_ch.temp_tenths),
  .out_div_zero    (out_ch.div_zero)
);

// ===== dv/temperature_sensor_compensation_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench: calibrated temperature compensation checked against an in-bench predictor.
module temperature_sensor_compensation_unit_tb;
  import tscu_pkg::*;

  // Run shape
  localparam int N_RAND_SETS    = 8;     // random calibration sets after the directed part
  localparam int ITEMS_PER_SET  = 56;
  localparam int STALL_SET      = 3;     // set where the receiver holds off for a long stretch
  localparam int STALL_ITEMS    = 80;    // more than the pipeline holds, so the input backs up
  localparam int LONG_STALL     = 150;
  localparam int QUIET_SETS     = 2;     // last sets run without any idling
  localparam int TAIL_CYCLES    = 40;    // longer than a reading takes through the pipeline
  localparam int WATCHDOG_LIMIT = 4000;

  // Calibration words as the block holds them
  typedef struct packed {
    logic [RAW_W-1:0]        ac5;
    logic [RAW_W-1:0]        ac6;
    logic signed [RAW_W-1:0] mc;
    logic signed [RAW_W-1:0] md;
  } calib_t;

  // One compensated reading
  typedef struct packed {
    logic signed [OUT_W-1:0] temp_tenths;
    logic                    div_zero;
  } tenths_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [RAW_W-1:0] cfg_wdata = '0;

  tscu_in_if  in_bus ();
  tscu_out_if out_bus ();

  temperature_sensor_compensation_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Bench copy of the calibration registers; matches reset state of the block
  calib_t cal = '0;

  logic [RAW_W-1:0] raw_q[$];       // readings waiting to be offered
  tenths_t expected_q[$];           // predicted results, oldest first

  bit idle_en = 1'b1;               // random idling on both sides
  int stall_token = 0;              // bumped to request one long receiver hold-off
  int stall_seen = 0;
  int src_gap = 0;
  int rx_gap = 0;
  int stuck_cycles = 0;

  int n_sent = 0;
  int n_checked = 0;
  int n_dz = 0;
  int n_sets = 0;
  int errors = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer compensation: X1 scaled offset, X2 division term, floor shift by 4.
  // SystemVerilog signed division truncates toward zero, as the scheme asks.
  function automatic tenths_t compensate(logic [RAW_W-1:0] raw, calib_t c);
    longint r, a5, a6, mc, md;
    longint x1, den, x2, res;
    tenths_t t;
    r   = longint'(raw);
    a5  = longint'(c.ac5);
    a6  = longint'(c.ac6);
    mc  = longint'($signed(c.mc));
    md  = longint'($signed(c.md));
    x1  = ((r - a6) * a5) / 32768;
    den = x1 + md;
    x2  = 0;
    t.div_zero = 1'b0;
    if (den == 0) begin
      // zero divisor: division term dropped, flag raised
      t.div_zero = 1'b1;
    end else begin
      x2 = (mc * 2048) / den;
    end
    res = (x1 + x2 + 8) >>> 4;
    t.temp_tenths = res[OUT_W-1:0];
    return t;
  endfunction

  // First reading that lands on a zero divisor under c, or -1 when none does
  function automatic int find_zero_div_raw(calib_t c);
    tenths_t t;
    for (int v = 0; v < 65536; v++) begin
      t = compensate(v[RAW_W-1:0], c);
      if (t.div_zero) return v;
    end
    return -1;
  endfunction

  // Calibration word biased toward the extremes
  function automatic logic [RAW_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // Reading mix: plain random, zero-divisor hits and their neighbors (tiny
  // divisors, big quotients), readings near ac6, and the range ends
  function automatic logic [RAW_W-1:0] pick_raw(calib_t c, int zraw);
    int off;
    off = $urandom_range(0, 6) - 3;
    case ($urandom_range(0, 9))
      0: return (zraw >= 0) ? zraw[RAW_W-1:0] : RAW_W'($urandom());
      1: return (zraw >= 0) ? RAW_W'(zraw + off) : RAW_W'($urandom());
      2: return c.ac6 + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
      3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [RAW_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Only called with the block idle; the mirror is read at input transfers only
  task automatic apply_calibration(calib_t c);
    write_reg(CFG_AC5, c.ac5);
    write_reg(CFG_AC6, c.ac6);
    write_reg(CFG_MC, c.mc);
    write_reg(CFG_MD, c.md);
    cal = c;
    n_sets++;
  endtask

  // Sender pauses here until every predicted result has been seen.
  // Sampled on the falling edge so the posedge processes have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (raw_q.size() != 0 || in_bus.valid || expected_q.size() != 0);
  endtask

  // Driver: offers queued readings, holds a reading until it transfers,
  // and inserts random idle bursts between readings
  always @(posedge clk) begin : reading_driver
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.raw_temp <= '0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_q.push_back(compensate(in_bus.raw_temp, cal));
        n_sent++;
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (raw_q.size() != 0 && idle_en && $urandom_range(0, 15) == 0) begin
          src_gap = $urandom_range(0, 17);  // start a random-length idle burst
          in_bus.valid <= 1'b0;
        end else if (raw_q.size() != 0) begin
          in_bus.raw_temp <= raw_q.pop_front();
          in_bus.valid    <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction and
  // drives ready with random bursts and the occasional long hold-off
  always @(posedge clk) begin : result_monitor
    tenths_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: temp_tenths=%0d div_zero=%0b",
                   $time, out_bus.temp_tenths, out_bus.div_zero);
        end else begin
          want = expected_q.pop_front();
          if (want.div_zero) n_dz++;
          if (out_bus.temp_tenths !== want.temp_tenths) begin
            errors++;
            $display("%0t: temp_tenths mismatch: expected %0d, got %0d",
                     $time, want.temp_tenths, out_bus.temp_tenths);
          end
          if (out_bus.div_zero !== want.div_zero) begin
            errors++;
            $display("%0t: div_zero mismatch: expected %0b, got %0b",
                     $time, want.div_zero, out_bus.div_zero);
          end
        end
      end
      if (stall_seen != stall_token) begin
        stall_seen = stall_token;
        rx_gap = LONG_STALL;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        rx_gap = $urandom_range(0, 17);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_bus.valid && in_bus.ready) ||
        (out_bus.valid && out_bus.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    calib_t c;
    int zraw;
    int n_items;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration is all zero: X1 is 0 and every reading divides by zero
    raw_q.push_back(16'h0000);
    raw_q.push_back(16'hFFFF);
    raw_q.push_back(16'h0001);
    wait_drained();

    // Unity gain: X1 = raw - ac6, so raw 1500 hits a zero divisor with md = -500;
    // neighbors give divisors of +-1, i.e. the largest quotients
    c = '{ac5: 16'd32768, ac6: 16'd1000, mc: -16'sd32768, md: -16'sd500};
    apply_calibration(c);
    raw_q.push_back(16'd1500);
    raw_q.push_back(16'd1499);
    raw_q.push_back(16'd1501);
    raw_q.push_back(16'd1000);
    raw_q.push_back(16'h0000);
    raw_q.push_back(16'hFFFF);
    wait_drained();

    // Largest positive X1 and positive numerator
    c = '{ac5: 16'hFFFF, ac6: 16'h0000, mc: 16'sh7FFF, md: 16'sh7FFF};
    apply_calibration(c);
    raw_q.push_back(16'h0000);
    raw_q.push_back(16'hFFFF);
    raw_q.push_back(16'h8000);
    raw_q.push_back(16'h7FFF);
    wait_drained();

    // Largest negative X1 with the most negative md and mc
    c = '{ac5: 16'hFFFF, ac6: 16'hFFFF, mc: -16'sd32768, md: -16'sd32768};
    apply_calibration(c);
    raw_q.push_back(16'h0000);
    raw_q.push_back(16'hFFFF);
    raw_q.push_back(16'h5555);
    wait_drained();

    // A realistic calibration set around room temperature
    c = '{ac5: 16'd24875, ac6: 16'd16000, mc: -16'sd11786, md: 16'sd2800};
    apply_calibration(c);
    raw_q.push_back(16'd27898);
    raw_q.push_back(16'd16000);
    raw_q.push_back(16'd31000);
    raw_q.push_back(16'hAAAA);
    wait_drained();

    // Random calibration sets; the last few with no idling on either side
    for (int s = 0; s < N_RAND_SETS; s++) begin
      c.ac5 = pick_word();
      c.ac6 = pick_word();
      c.mc  = pick_word();
      c.md  = pick_word();
      if (s == 1) c.ac5 = 16'd32768;  // unity gain makes zero divisors easy to reach
      apply_calibration(c);
      zraw = find_zero_div_raw(c);
      idle_en <= (s < N_RAND_SETS - QUIET_SETS) && (s != STALL_SET);
      n_items = ITEMS_PER_SET;
      if (s == STALL_SET) begin
        // receiver holds off while the sender keeps offering back to back
        stall_token <= stall_token + 1;
        n_items = STALL_ITEMS;
      end
      for (int i = 0; i < n_items; i++) raw_q.push_back(pick_raw(c, zraw));
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d calibration sets incl. range extremes; %0d readings sent, %0d checked.",
             n_sets, n_sent, n_checked);
    $display("%0d results hit a zero divisor; one long receiver hold-off backed up the input.",
             n_dz);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived",
               $time, errors, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== temperature_sensor_compensation_unit.f =====
rtl/core/tscu_pkg.sv
rtl/core/tscu_in_if.sv
rtl/core/tscu_out_if.sv
rtl/core/tscu_divider.sv
rtl/core/temperature_sensor_compensation_unit.sv
rtl/core/tscu_checker.sv
dv/temperature_sensor_compensation_unit_tb.sv
